// File: design/dhhc_pkg.sv
`timescale 1ns / 1ps

package dhhc_pkg;

	localparam int RAW_W    = 16;
	localparam int HEIGHT_W = 14;
	localparam int SCALE_W  = 16;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 2;
	localparam int FRAC_H   = 12;
	localparam int DEPTH_W  = RAW_W + SCALE_W;
	localparam int H_W      = DEPTH_W + 2;
	localparam int OFS_W    = 20;
	localparam int X_W      = OFS_W + 3;
	localparam int T_W      = 16;
	localparam int RECIP_K  = 32;
	localparam int RECIP_W  = 26;
	localparam int PROD_W   = X_W + RECIP_W;
	localparam int DIFF_W   = 10;
	localparam int BYTE_W   = 8;
	localparam int OUT_W    = 3 * BYTE_W;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [IDX_W-1:0] REG_CAMERA_HEIGHT = 2'd0;
	localparam logic [IDX_W-1:0] REG_DEPTH_SCALE   = 2'd1;

	localparam logic [HEIGHT_W-1:0] CAMERA_HEIGHT_RST = 14'd2500;
	localparam logic [SCALE_W-1:0]  DEPTH_SCALE_RST   = 16'd4096;

	// Band edges in millimetres with FRAC_H fraction bits.
	localparam logic signed [H_W-1:0] BAND1_FX = H_W'(150 << FRAC_H);
	localparam logic signed [H_W-1:0] BAND2_FX = H_W'(300 << FRAC_H);
	localparam logic signed [H_W-1:0] BAND3_FX = H_W'(450 << FRAC_H);

	// t = floor(8 * d / 75); the reciprocal is floor(2^32 / 75).
	localparam logic [RECIP_W-1:0] RECIP_M = 26'd57266230;
	localparam logic [7:0]         BAND_DIV = 8'd75;

	typedef enum logic [2:0] {
		KIND_NODATA,
		KIND_BLUE,
		KIND_BAND1,
		KIND_BAND2,
		KIND_BAND3,
		KIND_RED
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [OFS_W-1:0] offset;
	} item_t;

	typedef logic [2:0][BYTE_W-1:0] rgb_t;
	typedef logic [2:0][DIFF_W-1:0] diff_t;

	// Start colour of each kind, index 0 blue, 1 green, 2 red.
	function automatic rgb_t kind_base(kind_t k);
		rgb_t c;
		unique case (k)
			KIND_NODATA: c = {8'd30, 8'd30, 8'd30};
			KIND_BLUE:   c = {8'd0, 8'd40, 8'd200};
			KIND_BAND1:  c = {8'd0, 8'd40, 8'd200};
			KIND_BAND2:  c = {8'd0, 8'd200, 8'd0};
			KIND_BAND3:  c = {8'd255, 8'd255, 8'd0};
			KIND_RED:    c = {8'd255, 8'd0, 8'd0};
			default:     c = {8'd30, 8'd30, 8'd30};
		endcase
		return c;
	endfunction

	// End minus start colour within a band; zero for the flat colours.
	function automatic diff_t kind_diff(kind_t k);
		diff_t d;
		unique case (k)
			KIND_BAND1: d = {10'sd0, 10'sd160, -10'sd200};
			KIND_BAND2: d = {10'sd255, 10'sd55, 10'sd0};
			KIND_BAND3: d = {10'sd0, -10'sd255, 10'sd0};
			default:    d = '0;
		endcase
		return d;
	endfunction

endpackage

// File: design/dhhc_front.sv
`timescale 1ns / 1ps

module dhhc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [dhhc_pkg::RAW_W-1:0]     depth_sample,
	input  logic [dhhc_pkg::HEIGHT_W-1:0]  camera_height,
	input  logic [dhhc_pkg::SCALE_W-1:0]   depth_scale,
	output logic                           out_valid,
	input  logic                           out_ready,
	output dhhc_pkg::item_t                out_item
);
	import dhhc_pkg::*;

	logic                   v_s1;
	logic                   zero_s1;
	logic [DEPTH_W-1:0]     depth_mm_s1;
	logic                   v_s2;
	item_t                  item_s2;
	logic                   ready_s1;
	logic                   ready_s2;
	logic signed [H_W-1:0]  height;
	item_t                  item_d;

	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			zero_s1     <= (depth_sample == '0);
			depth_mm_s1 <= DEPTH_W'(depth_sample) * DEPTH_W'(depth_scale);
		end
	end

	assign height = $signed({{(H_W-HEIGHT_W-FRAC_H){1'b0}}, camera_height, {FRAC_H{1'b0}}})
		- $signed({2'b00, depth_mm_s1});

	always_comb begin
		item_d.offset = '0;
		if (zero_s1) begin
			item_d.kind = KIND_NODATA;
		end else if (height <= 0) begin
			item_d.kind = KIND_BLUE;
		end else if (height < BAND1_FX) begin
			item_d.kind   = KIND_BAND1;
			item_d.offset = height[OFS_W-1:0];
		end else if (height < BAND2_FX) begin
			item_d.kind   = KIND_BAND2;
			item_d.offset = OFS_W'(height - BAND1_FX);
		end else if (height < BAND3_FX) begin
			item_d.kind   = KIND_BAND3;
			item_d.offset = OFS_W'(height - BAND2_FX);
		end else begin
			item_d.kind = KIND_RED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			item_s2 <= item_d;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

// File: design/dhhc_fifo.sv
`timescale 1ns / 1ps

module dhhc_fifo #(
	parameter int DEPTH = dhhc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  dhhc_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output dhhc_pkg::item_t pop_item
);
	import dhhc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

// File: design/dhhc_back.sv
`timescale 1ns / 1ps

module dhhc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dhhc_pkg::item_t               in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dhhc_pkg::OUT_W-1:0]    out_rgb
);
	import dhhc_pkg::*;

	logic                 v_s3;
	kind_t                kind_s3;
	logic [X_W-1:0]       x_s3;
	logic [PROD_W-1:0]    prod_s3;
	logic                 v_s4;
	kind_t                kind_s4;
	logic [T_W-1:0]       t_s4;
	logic [X_W-1:0]       rem_s4;
	logic                 v_s5;
	rgb_t                 rgb_s5;
	logic                 ready_s3;
	logic                 ready_s4;
	logic                 ready_s5;
	logic [X_W-1:0]       x_in;
	logic [T_W-1:0]       q_est;
	logic [X_W-1:0]       rem;
	logic [T_W-1:0]       t_d;
	logic [X_W-1:0]       rem_d;
	rgb_t                 base;
	diff_t                diff;
	rgb_t                 rgb_d;
	logic signed [27:0]   acc [3];

	assign ready_s5 = !v_s5 || out_ready;
	assign ready_s4 = !v_s4 || ready_s5;
	assign ready_s3 = !v_s3 || ready_s4;
	assign in_ready = ready_s3;

	// Offset times 16/150 is offset times 8/75.
	assign x_in = {in_item.offset, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ready_s3) begin
				v_s3 <= in_valid;
			end
			if (ready_s4) begin
				v_s4 <= v_s3;
			end
			if (ready_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			kind_s3 <= in_item.kind;
			x_s3    <= x_in;
			prod_s3 <= PROD_W'(x_in) * PROD_W'(RECIP_M);
		end
	end

	// The reciprocal estimate is the quotient or one below it.
	assign q_est = prod_s3[RECIP_K +: T_W];
	assign rem   = x_s3 - X_W'(q_est * X_W'(BAND_DIV));

	always_comb begin
		if (rem >= X_W'(BAND_DIV)) begin
			t_d   = q_est + 1'b1;
			rem_d = rem - X_W'(BAND_DIV);
		end else begin
			t_d   = q_est;
			rem_d = rem;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && v_s3) begin
			kind_s4 <= kind_s3;
			t_s4    <= t_d;
			rem_s4  <= rem_d;
		end
	end

	assign base = kind_base(kind_s4);
	assign diff = kind_diff(kind_s4);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc[c] = $signed({4'b0000, base[c], 16'h8000})
				+ 28'($signed(diff[c]) * $signed({1'b0, t_s4}));
			rgb_d[c] = acc[c][23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && v_s4) begin
			rgb_s5 <= rgb_d;
		end
	end

	assign out_valid = v_s5;
	assign out_rgb   = rgb_s5;

	a_rem_exact: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (rem_s4 < X_W'(BAND_DIV)))
		else $error("band quotient off by more than one");

	a_flat_no_blend: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && (kind_s4 == KIND_NODATA || kind_s4 == KIND_BLUE || kind_s4 == KIND_RED))
		|-> (diff == '0))
		else $error("flat colour carries a blend slope");

endmodule

// File: design/depth_height_heatmap_colorizer_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   depth_sample[15:0]
// m_axis    out  m_axis_tvalid/m_axis_tready   blue[7:0], green[15:8], red[23:16]
// cfg       in   cfg_we (no ready)             cfg_index, cfg_data[15:0]
//
// One pixel is accepted per cycle when nothing stalls; its colour reaches m_axis after
// its transfer on s_axis loads the first front stage and it then passes through the second
// front stage, a queue slot and the three back stages in that order. The rate is one
// pixel per cycle when nothing stalls; the depth-scale and reciprocal multipliers each
// have a register after them to keep the stages short.
// A small queue sits between the front and the back, so a stall on m_axis fills the
// back stages and the queue before the front, and finally s_axis, stop.
// Reset is asynchronous and active low; it empties the pipeline and queue and loads
// the register defaults (camera height 2500 mm, depth scale 1.0 mm per count).

module depth_height_heatmap_colorizer_unit #(
	parameter int QUEUE_DEPTH = dhhc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [dhhc_pkg::RAW_W-1:0]    s_axis_tdata,   // [15:0] depth_sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [dhhc_pkg::OUT_W-1:0]    m_axis_tdata,   // [7:0] blue_byte, [15:8] green_byte,
	                                                      // [23:16] red_byte
	input  logic                          cfg_we,
	input  logic [dhhc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dhhc_pkg::CFG_W-1:0]    cfg_data
);
	import dhhc_pkg::*;

	logic [HEIGHT_W-1:0] camera_height_q;
	logic [SCALE_W-1:0]  depth_scale_q;
	logic                front_valid;
	logic                front_ready;
	item_t               front_item;
	logic                queue_valid;
	logic                queue_ready;
	item_t               queue_item;

	// Configuration registers. Only the low register width of the data is kept, and
	// writes to indexes past the depth scale are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_height_q <= CAMERA_HEIGHT_RST;
			depth_scale_q   <= DEPTH_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAMERA_HEIGHT: camera_height_q <= cfg_data[HEIGHT_W-1:0];
				REG_DEPTH_SCALE:   depth_scale_q   <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// The front scales the depth, forms the height above the floor and sorts the
	// pixel into no-data, flat blue, one of three blend bands, or flat red.
	dhhc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.depth_sample  (s_axis_tdata),
		.camera_height (camera_height_q),
		.depth_scale   (depth_scale_q),
		.out_valid     (front_valid),
		.out_ready     (front_ready),
		.out_item      (front_item)
	);

	dhhc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_item   (queue_item)
	);

	// The back turns the band offset into a 16-bit fraction through a reciprocal
	// multiply with one correction step, then blends the band's end colours with
	// round-half-up and holds the result in the output register.
	dhhc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (queue_valid),
		.in_ready  (queue_ready),
		.in_item   (queue_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rgb   (m_axis_tdata)
	);

endmodule
